// File: hdl/abe_pkg.sv
// ----------------------------------------------------------------------------
// abe_pkg: shared types and constants for the allocation bitmap engine
// Opcodes, sequencer states, item structs and the word scan result.
// ----------------------------------------------------------------------------
package abe_pkg;

  // Fixed field widths
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;    // bit offset inside a word
  localparam int SIZE_W    = 11;   // map size, run length, run counter
  localparam int POS_W     = 10;   // index and position fields
  localparam int WCNT_W    = 6;    // word counter over a map of up to 2047 bits
  localparam int SIZE_MAX  = 2047;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_CLR  = 2'd1,
    OP_TEST = 2'd2,
    OP_FIND = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_FIND
  } state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [POS_W-1:0]    index;
    logic [SIZE_W-1:0]   run_length;
  } in_item_t;

  typedef struct packed {
    logic                bit_value;
    logic                found;
    logic [POS_W-1:0]    position;
    logic                status;
  } out_item_t;

  // Result of scanning one word for a free run
  typedef struct packed {
    logic                hit;
    logic [BIT_W-1:0]    hit_bit;
    logic [SIZE_W-1:0]   run_out;
  } scan_res_t;

endpackage

// File: hdl/abe_store.sv
// ----------------------------------------------------------------------------
// abe_store: occupancy bitmap word memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module abe_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic [abe_pkg::WORD_BITS-1:0]      wdata,
  input  logic [AW-1:0]                      raddr,
  output logic [abe_pkg::WORD_BITS-1:0]      rdata
);

  logic [abe_pkg::WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/abe_scan.sv
// ----------------------------------------------------------------------------
// abe_scan: free run scan over one bitmap word
// Finds the lowest bit at which a run of free bits reaches the wanted
// length, counting the run carried in from lower words.
// ----------------------------------------------------------------------------
module abe_scan (
  input  logic [abe_pkg::WORD_BITS-1:0] word_i,
  input  logic [abe_pkg::SIZE_W-1:0]    rem_i,   // bits of this word still in the map
  input  logic [abe_pkg::SIZE_W-1:0]    run_i,   // free run carried in
  input  logic [abe_pkg::SIZE_W-1:0]    want_i,
  output abe_pkg::scan_res_t            res_o
);

  localparam int NB = abe_pkg::WORD_BITS;
  localparam int NL = abe_pkg::BIT_W;

  logic [NB-1:0]              occ;
  logic [NB-1:0]              has   [NL+1];
  logic [abe_pkg::BIT_W-1:0]  last  [NL+1][NB];
  logic [abe_pkg::SIZE_W:0]   run_len [NB];
  logic [NB-1:0]              ok;

  // Bits past the end of the map count as occupied
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      occ[j] = word_i[j] || !(abe_pkg::SIZE_W'(j) < rem_i);
    end
  end

  // Prefix search: highest occupied bit at or below each bit, log depth
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      has[0][j]  = occ[j];
      last[0][j] = abe_pkg::BIT_W'(j);
    end
    for (int l = 0; l < NL; l++) begin
      for (int j = 0; j < NB; j++) begin
        if (j >= (1 << l) && !has[l][j]) begin
          has[l+1][j]  = has[l][j - (1 << l)];
          last[l+1][j] = last[l][j - (1 << l)];
        end else begin
          has[l+1][j]  = has[l][j];
          last[l+1][j] = last[l][j];
        end
      end
    end
  end

  // Run length ending at each bit and the wanted-length check
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      if (has[NL][j]) begin
        run_len[j] = (abe_pkg::SIZE_W+1)'(j) - (abe_pkg::SIZE_W+1)'(last[NL][j]);
      end else begin
        run_len[j] = (abe_pkg::SIZE_W+1)'(run_i) + (abe_pkg::SIZE_W+1)'(j)
                   + (abe_pkg::SIZE_W+1)'(1);
      end
      ok[j] = !occ[j] && (run_len[j] >= {1'b0, want_i});
    end
  end

  // Lowest hit and saturated run out of the word
  always_comb begin
    res_o.hit     = |ok;
    res_o.hit_bit = '0;
    for (int j = NB - 1; j >= 0; j--) begin
      if (ok[j]) begin
        res_o.hit_bit = abe_pkg::BIT_W'(j);
      end
    end
    if (run_len[NB-1] > (abe_pkg::SIZE_W+1)'(abe_pkg::SIZE_MAX)) begin
      res_o.run_out = abe_pkg::SIZE_W'(abe_pkg::SIZE_MAX);
    end else begin
      res_o.run_out = run_len[NB-1][abe_pkg::SIZE_W-1:0];
    end
  end

endmodule

// File: hdl/allocation_bitmap_engine.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_engine: first-fit bitmap allocator
// Set, clear and test single bits, or find the lowest free run of a length.
//
//   port group      dir   handshake
//   in_item         in    start high while busy low
//   out_item        out   out_valid strobe, one cycle, no backpressure
//   cfg_wdata       in    cfg_we, taken at once
//
// Set, clear and test: the word is read, then written back or reported.
// An index out of range for set, clear or test, or a zero run length or an
// empty map for find, is answered straight from idle. Find reads the map one
// 32-bit word after another through the word scan unit, until a hit or the end.
// After reset a clearing pass writes every word with busy high. The result is
// registered and appears in the cycle after the last work cycle.
// ----------------------------------------------------------------------------
module allocation_bitmap_engine #(
  parameter int MAP_BITS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  abe_pkg::in_item_t               in_item,
  input  logic                            cfg_we,
  input  logic [abe_pkg::SIZE_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output abe_pkg::out_item_t              out_item
);

  localparam int WORDS    = (MAP_BITS + 31) / 32;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SIZE_CAP = (MAP_BITS > abe_pkg::SIZE_MAX) ? abe_pkg::SIZE_MAX : MAP_BITS;
  localparam int SW       = abe_pkg::SIZE_W;
  localparam int WB       = abe_pkg::WORD_BITS;

  abe_pkg::state_t              state_r, state_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [SW-1:0]                map_size_r;
  abe_pkg::opcode_t             op_r, op_nxt;
  logic [abe_pkg::POS_W-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]                want_r, want_nxt;
  logic [abe_pkg::WCNT_W-1:0]   ev_r, ev_nxt;
  logic [SW-1:0]                run_r, run_nxt;
  logic                         out_valid_r, out_valid_nxt;
  abe_pkg::out_item_t           out_item_r, out_item_nxt;

  logic [SW-1:0]                size_eff;
  logic [SW-1:0]                base;
  logic [SW-1:0]                rem;
  logic [SW:0]                  run_end;
  logic [SW:0]                  run_start;
  logic [WB-1:0]                bit_mask;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [WB-1:0]                mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [WB-1:0]                mem_rdata;
  abe_pkg::scan_res_t           scan;

  // Bitmap word store
  abe_store #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Word scan unit, used by find
  abe_scan u_scan (
    .word_i (mem_rdata),
    .rem_i  (rem),
    .run_i  (run_r),
    .want_i (want_r),
    .res_o  (scan)
  );

  // Size in use, capped at the store capacity
  assign size_eff = (32'(map_size_r) > SIZE_CAP) ? SW'(SIZE_CAP) : map_size_r;

  // Word under scan and the run position arithmetic
  assign base      = {ev_r, {abe_pkg::BIT_W{1'b0}}};
  assign rem       = size_eff - base;
  assign run_end   = {1'b0, base} + (SW+1)'(scan.hit_bit);
  assign run_start = run_end + (SW+1)'(1) - {1'b0, want_r};
  assign bit_mask  = WB'(1) << idx_r[abe_pkg::BIT_W-1:0];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= SW'(1024);
    end else if (cfg_we) begin
      map_size_r <= cfg_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abe_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    want_r     <= want_nxt;
    ev_r       <= ev_nxt;
    run_r      <= run_nxt;
    out_item_r <= out_item_nxt;
  end

  // Sequencer: next state, memory control and result
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    want_nxt      = want_r;
    ev_nxt        = ev_r;
    run_nxt       = run_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(idx_r >> abe_pkg::BIT_W);
    mem_wdata     = '0;
    mem_raddr     = AW'(ev_r + abe_pkg::WCNT_W'(1));

    case (state_r)
      // Zero the store word by word after reset
      abe_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = abe_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      // Take an item, start the read or answer at once
      abe_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt       = in_item.opcode;
          idx_nxt      = in_item.index;
          want_nxt     = in_item.run_length;
          ev_nxt       = '0;
          run_nxt      = '0;
          out_item_nxt = '0;
          if (in_item.opcode == abe_pkg::OP_FIND) begin
            mem_raddr = '0;
            if (in_item.run_length == '0 || size_eff == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = abe_pkg::ST_FIND;
            end
          end else if ({1'b0, in_item.index} >= size_eff) begin
            out_item_nxt.status = 1'b1;
            out_valid_nxt       = 1'b1;
          end else begin
            mem_raddr = AW'(in_item.index >> abe_pkg::BIT_W);
            state_nxt = abe_pkg::ST_RMW;
          end
        end
      end

      // Word is back: modify and write, or report the bit
      abe_pkg::ST_RMW: begin
        out_valid_nxt = 1'b1;
        state_nxt     = abe_pkg::ST_IDLE;
        case (op_r)
          abe_pkg::OP_SET: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | bit_mask;
          end
          abe_pkg::OP_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~bit_mask;
          end
          abe_pkg::OP_TEST: begin
            out_item_nxt.bit_value = |(mem_rdata & bit_mask);
          end
          default: begin
            out_item_nxt.bit_value = 1'b0;
          end
        endcase
      end

      // One word per cycle; the next word's read is already under way
      abe_pkg::ST_FIND: begin
        if (scan.hit) begin
          out_item_nxt.found    = 1'b1;
          out_item_nxt.position = run_start[abe_pkg::POS_W-1:0];
          out_valid_nxt         = 1'b1;
          state_nxt             = abe_pkg::ST_IDLE;
        end else if (rem <= SW'(WB)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = abe_pkg::ST_IDLE;
        end else begin
          ev_nxt  = ev_r + abe_pkg::WCNT_W'(1);
          run_nxt = scan.run_out;
        end
      end

      default: begin
        state_nxt = abe_pkg::ST_IDLE;
      end
    endcase
  end

  // Ports
  assign busy      = (state_r != abe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/abe_result_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abe_result_monitor: result checker for the allocation bitmap engine
// Watches accepted requests and size writes, keeps its own copy of the
// occupancy map, predicts each result and compares it against the block.
// ----------------------------------------------------------------------------
module abe_result_monitor #(
  parameter int MAP_BITS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  abe_pkg::in_item_t          in_item,
  input  logic                       cfg_we,
  input  logic [abe_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       out_valid,
  input  abe_pkg::out_item_t         out_item,
  output int                         mismatches,
  output int                         outstanding
);

  logic [MAP_BITS-1:0]        occ_map;
  logic [abe_pkg::SIZE_W-1:0] map_size_q;
  abe_pkg::out_item_t         pending_results[$];
  int                         err_cnt;
  int                         result_cnt;

  // Apply one request to the local map and return the result it gives
  function automatic abe_pkg::out_item_t predict_request(input abe_pkg::in_item_t req);
    abe_pkg::out_item_t rsp;
    int unsigned        limit;
    int unsigned        run;
    int unsigned        first;
    int unsigned        i;
    rsp   = '0;
    run   = 0;
    first = 0;
    limit = (map_size_q > MAP_BITS) ? MAP_BITS : map_size_q;
    if (req.opcode == abe_pkg::OP_FIND) begin
      // first fit: lowest start of a run of free bits inside the map in use
      if (req.run_length != 0) begin
        for (i = 0; i < limit && !rsp.found; i++) begin
          if (!occ_map[i]) begin
            if (run == 0) first = i;
            run++;
            if (run >= req.run_length) begin
              rsp.found    = 1'b1;
              rsp.position = abe_pkg::POS_W'(first);
            end
          end else begin
            run = 0;
          end
        end
      end
    end else if (req.index >= limit) begin
      rsp.status = 1'b1;
    end else begin
      case (req.opcode)
        abe_pkg::OP_SET: occ_map[req.index] = 1'b1;
        abe_pkg::OP_CLR: occ_map[req.index] = 1'b0;
        default:         rsp.bit_value = occ_map[req.index];
      endcase
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    abe_pkg::out_item_t want;
    if (!rst_n) begin
      occ_map    = '0;
      map_size_q = abe_pkg::SIZE_W'(1024);
      pending_results.delete();
      err_cnt    = 0;
      result_cnt = 0;
    end else begin
      // results first: a new request never finishes in the cycle it is taken
      if (out_valid) begin
        result_cnt++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"%0t: result %0d with no request pending: ",
                      "bit %0b found %0b pos %0d st %0b"},
                     $realtime, result_cnt, out_item.bit_value, out_item.found,
                     out_item.position, out_item.status);
        end else begin
          want = pending_results.pop_front();
          if (out_item.bit_value !== want.bit_value || out_item.found !== want.found ||
              out_item.position !== want.position || out_item.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: result %0d exp bit %0b found %0b pos %0d st %0b, ",
                        "got bit %0b found %0b pos %0d st %0b"},
                       $realtime, result_cnt, want.bit_value, want.found, want.position,
                       want.status, out_item.bit_value, out_item.found, out_item.position,
                       out_item.status);
          end
        end
      end
      if (start && !busy) pending_results.push_back(predict_request(in_item));
      if (cfg_we) map_size_q = cfg_wdata;
    end
    mismatches  <= err_cnt;
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/allocation_bitmap_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// allocation_bitmap_engine_tb: testbench top for the allocation bitmap engine
// Drives directed and random set, clear, test and find requests over several
// map sizes and sender idle rates; the monitor predicts and checks results.
// ----------------------------------------------------------------------------
module allocation_bitmap_engine_tb;

  localparam int MAP_BITS    = 1024;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 215;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [abe_pkg::SIZE_W-1:0] cfg_wdata = '0;
  abe_pkg::in_item_t          in_item   = '0;
  logic                       busy;
  logic                       out_valid;
  abe_pkg::out_item_t         out_item;
  int                         mismatches;
  int                         outstanding;
  int                         idle_pct     = 0;
  int                         quiet_cycles = 0;
  int unsigned                cur_size     = MAP_BITS;

  always #2 clk = ~clk;

  allocation_bitmap_engine #(.MAP_BITS(MAP_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  abe_result_monitor #(.MAP_BITS(MAP_BITS)) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: too long without any item, result or size write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic abe_pkg::in_item_t make_req(input abe_pkg::opcode_t op,
                                                 input int unsigned idx,
                                                 input int unsigned len);
    abe_pkg::in_item_t req;
    req.opcode     = op;
    req.index      = abe_pkg::POS_W'(idx);
    req.run_length = abe_pkg::SIZE_W'(len);
    return req;
  endfunction

  // Random request; set_pct shifts the map toward dense or sparse
  function automatic abe_pkg::in_item_t random_req(input int unsigned set_pct);
    abe_pkg::opcode_t op;
    int unsigned      r;
    int unsigned      idx;
    int unsigned      len;
    r = $urandom_range(99);
    if (r < set_pct)  op = abe_pkg::OP_SET;
    else if (r < 60)  op = abe_pkg::OP_CLR;
    else if (r < 75)  op = abe_pkg::OP_TEST;
    else              op = abe_pkg::OP_FIND;
    // mostly in range, sometimes anywhere
    if (cur_size != 0 && $urandom_range(99) < 88) idx = $urandom_range(cur_size - 1);
    else                                          idx = $urandom_range(MAP_BITS - 1);
    r = $urandom_range(99);
    if (r < 50)       len = $urandom_range(4, 1);
    else if (r < 80)  len = $urandom_range(16, 1);
    else if (r < 92)  len = $urandom_range((cur_size > 1) ? cur_size : 1, 1);
    else if (r < 96)  len = 0;
    else              len = $urandom_range(2047);
    return make_req(op, idx, len);
  endfunction

  // Hand one item over; gaps before it follow idle_pct
  task automatic send(input abe_pkg::in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every pending result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_size(input int unsigned value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= abe_pkg::SIZE_W'(value);
    cur_size   = (value > MAP_BITS) ? MAP_BITS : value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned size, input int idle,
                           input int unsigned set_pct);
    write_size(size);
    idle_pct = idle;
    repeat (PHASE_ITEMS) send(random_req(set_pct));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty map at full size, field extremes, zero and oversize runs
    send(make_req(abe_pkg::OP_FIND, 0, 1));
    send(make_req(abe_pkg::OP_FIND, 1023, 0));
    send(make_req(abe_pkg::OP_FIND, 0, 1024));
    send(make_req(abe_pkg::OP_FIND, 0, 2047));
    send(make_req(abe_pkg::OP_SET, 0, 0));
    send(make_req(abe_pkg::OP_SET, 1023, 2047));
    send(make_req(abe_pkg::OP_TEST, 0, 0));
    send(make_req(abe_pkg::OP_TEST, 1023, 0));
    send(make_req(abe_pkg::OP_TEST, 512, 0));
    send(make_req(abe_pkg::OP_FIND, 0, 1024));
    send(make_req(abe_pkg::OP_FIND, 0, 1022));
    send(make_req(abe_pkg::OP_CLR, 1023, 0));
    send(make_req(abe_pkg::OP_TEST, 1023, 0));
    // small map: out of range indexes, runs bounded by the size
    write_size(8);
    send(make_req(abe_pkg::OP_SET, 8, 0));
    send(make_req(abe_pkg::OP_TEST, 1023, 0));
    send(make_req(abe_pkg::OP_FIND, 0, 8));
    send(make_req(abe_pkg::OP_FIND, 0, 7));
    // empty map: everything out of range, find never hits
    write_size(0);
    send(make_req(abe_pkg::OP_SET, 0, 0));
    send(make_req(abe_pkg::OP_FIND, 0, 1));
    send(make_req(abe_pkg::OP_CLR, 0, 0));
    // size above capacity acts as full map; old bits survive the resize
    write_size(2047);
    send(make_req(abe_pkg::OP_TEST, 1023, 0));
    send(make_req(abe_pkg::OP_FIND, 0, 1024));
    send(make_req(abe_pkg::OP_CLR, 0, 0));
    // single bit map
    write_size(1);
    send(make_req(abe_pkg::OP_TEST, 0, 0));
    send(make_req(abe_pkg::OP_SET, 0, 0));
    send(make_req(abe_pkg::OP_TEST, 1, 0));

    // Random phases across sizes, densities and sender idle rates
    run_phase(1024, 0, 20);
    run_phase(64, 47, 30);
    run_phase(8, 6, 30);
    run_phase(2047, 0, 45);
    run_phase(1, 47, 30);
    run_phase($urandom_range(1023, 2), 6, 25);
    run_phase(1024, 47, 15);
    run_phase(0, 0, 30);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
